### hw/rtl/port_block_allocator_core_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef PORT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define PORT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pba_pkg.sv
package pba_pkg;

   localparam int MaxBlocks = 64;
   localparam int BlkIdxW   = $clog2(MaxBlocks);
   localparam int NblkW     = $clog2(MaxBlocks + 1);
   localparam int CntW      = 7;
   localparam int PortW     = 16;
   localparam int DivCntW   = $clog2(PortW);
   localparam int GroupSize = 8;
   localparam int GrpBitW   = $clog2(GroupSize);
   localparam int NumGroups = (MaxBlocks + GroupSize - 1) / GroupSize;
   localparam int GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
   localparam int ScanW     = GrpW + GrpBitW;
   localparam int CmpW      = (ScanW > NblkW) ? ScanW : NblkW;
   localparam int StatusW   = 3;
   localparam int CsrIdxW   = 2;

   localparam logic [StatusW-1:0] StOk       = 3'd0;
   localparam logic [StatusW-1:0] StNoneFree = 3'd1;
   localparam logic [StatusW-1:0] StCountBig = 3'd2;
   localparam logic [StatusW-1:0] StBadPort  = 3'd3;
   localparam logic [StatusW-1:0] StNotTaken = 3'd4;

   localparam logic [CsrIdxW-1:0] CsrMinPort   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMaxPort   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrBlockSize = 2'd2;

   localparam logic [PortW-1:0] BlockSizeReset = 16'd10;

   localparam logic KindAlloc = 1'b0;

   typedef struct packed {
      logic             kind;
      logic [PortW-1:0] port_count;
      logic [PortW-1:0] range_low_port;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [PortW-1:0]   low_port;
      logic [PortW-1:0]   high_port;
      logic [CntW-1:0]    taken_count;
   } rsp_type;

   typedef struct packed {
      logic               latch_req;
      logic               div_span;
      logic               div_port;
      logic               load_nblk;
      logic               zero_nblk;
      logic               scan_start;
      logic               scan_step;
      logic               grant_mul;
      logic               grant_fin;
      logic               free_clear;
      logic               set_status;
      logic [StatusW-1:0] status;
      logic               load_out;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic span_ok;
      logic count_big;
      logic port_bad;
      logic nblk_zero;
      logic total_zero;
      logic div_done;
      logic scan_hit;
      logic scan_last;
      logic free_bad;
      logic free_taken;
   } stat_type;

endpackage

### hw/rtl/pba_div.sv
// Restoring divider, one quotient bit per cycle. divisor must be nonzero.
module pba_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pba_pkg::PortW-1:0] dividend,
   input  logic [pba_pkg::PortW-1:0] divisor,
   output logic                      done,
   output logic [pba_pkg::PortW-1:0] quotient,
   output logic [pba_pkg::PortW-1:0] remainder
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [pba_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic [pba_pkg::PortW-1:0]   quo_ff, quo_in;
   logic [pba_pkg::PortW-1:0]   rem_ff, rem_in;
   logic [pba_pkg::PortW-1:0]   dsr_ff, dsr_in;
   logic [pba_pkg::PortW:0]     trial;
   logic [pba_pkg::PortW:0]     diff;
   logic                        ge;

   assign trial = {rem_ff, quo_ff[pba_pkg::PortW-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[pba_pkg::PortW-2:0], ge};
         rem_in = ge ? diff[pba_pkg::PortW-1:0] : trial[pba_pkg::PortW-1:0];
         cnt_in = cnt_ff + pba_pkg::DivCntW'(1);
         if (cnt_ff == pba_pkg::DivCntW'(pba_pkg::PortW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/pba_dp.sv
`include "port_block_allocator_core_defines.svh"

module pba_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [pba_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pba_pkg::PortW-1:0]   csr_wdata,
   input  pba_pkg::req_type            req_data,
   input  pba_pkg::cmd_type            cmd,
   output pba_pkg::stat_type           stat,
   output pba_pkg::rsp_type            rsp_data
);

   logic [pba_pkg::PortW-1:0]     min_ff, max_ff, bs_ff;
   logic [pba_pkg::MaxBlocks-1:0] taken_ff, taken_in;
   logic [pba_pkg::CntW-1:0]      total_ff, total_in;
   pba_pkg::req_type              req_ff;
   logic [pba_pkg::NblkW-1:0]     nblk_ff;
   logic [pba_pkg::GrpW-1:0]      grp_ff;
   logic [pba_pkg::BlkIdxW-1:0]   idx_ff;
   logic [pba_pkg::PortW-1:0]     prod_ff;
   logic [pba_pkg::StatusW-1:0]   st_ff;
   logic [pba_pkg::PortW-1:0]     lo_ff, hi_ff;
   pba_pkg::rsp_type              out_ff;

   logic                                        cfg_hit;
   logic                                        div_start, div_done;
   logic [pba_pkg::PortW-1:0]                   div_dend, div_q, div_r;
   logic [pba_pkg::NblkW-1:0]                   nblk_calc;
   logic [pba_pkg::GroupSize-1:0]               scan_cand;
   logic [pba_pkg::GrpBitW-1:0]                 hit_k;
   logic [pba_pkg::BlkIdxW-1:0]                 hit_idx;
   logic [pba_pkg::BlkIdxW+pba_pkg::PortW-1:0]  prod_full;
   logic [pba_pkg::PortW-1:0]                   lo_calc, hi_calc;
   logic [pba_pkg::PortW:0]                     end_calc;

   assign cfg_hit = csr_we && (csr_index == pba_pkg::CsrMinPort ||
                               csr_index == pba_pkg::CsrMaxPort ||
                               csr_index == pba_pkg::CsrBlockSize);

   assign div_start = cmd.div_span || cmd.div_port;
   assign div_dend  = cmd.div_span ? (max_ff - min_ff) : (req_ff.range_low_port - min_ff);

   pba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dend),
      .divisor   (bs_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // ceil(span / block_size), capped at the map size
   always_comb begin
      if (div_q >= pba_pkg::PortW'(pba_pkg::MaxBlocks)) begin
         nblk_calc = pba_pkg::NblkW'(pba_pkg::MaxBlocks);
      end else begin
         nblk_calc = pba_pkg::NblkW'(div_q) + pba_pkg::NblkW'(div_r != '0);
      end
   end

   // one group of the map per cycle, lowest free block below the count wins
   always_comb begin
      scan_cand = '0;
      hit_k     = '0;
      for (int k = 0; k < pba_pkg::GroupSize; k++) begin
         if (pba_pkg::CmpW'({grp_ff, pba_pkg::GrpBitW'(k)}) < pba_pkg::CmpW'(nblk_ff)) begin
            scan_cand[k] = ~taken_ff[pba_pkg::BlkIdxW'({grp_ff, pba_pkg::GrpBitW'(k)})];
         end
      end
      for (int k = pba_pkg::GroupSize - 1; k >= 0; k--) begin
         if (scan_cand[k]) begin
            hit_k = pba_pkg::GrpBitW'(k);
         end
      end
   end

   assign hit_idx   = pba_pkg::BlkIdxW'({grp_ff, hit_k});
   assign prod_full = idx_ff * bs_ff;

   // last block is cut short at the end of the span
   assign lo_calc  = min_ff + prod_ff;
   assign end_calc = {1'b0, lo_calc} + {1'b0, bs_ff};
   assign hi_calc  = (end_calc > {1'b0, max_ff}) ? (max_ff - pba_pkg::PortW'(1))
                                                 : (end_calc[pba_pkg::PortW-1:0]
                                                    - pba_pkg::PortW'(1));

   always_comb begin
      taken_in = taken_ff;
      total_in = total_ff;
      if (cmd.grant_fin) begin
         taken_in[idx_ff] = 1'b1;
         total_in         = total_ff + pba_pkg::CntW'(1);
      end
      if (cmd.free_clear) begin
         taken_in[div_q[pba_pkg::BlkIdxW-1:0]] = 1'b0;
         total_in                              = total_ff - pba_pkg::CntW'(1);
      end
      if (cfg_hit) begin
         taken_in = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= '0;
         bs_ff    <= pba_pkg::BlockSizeReset;
         taken_ff <= '0;
         total_ff <= '0;
      end else begin
         taken_ff <= taken_in;
         total_ff <= total_in;
         if (csr_we) begin
            case (csr_index)
               pba_pkg::CsrMinPort:   min_ff <= csr_wdata;
               pba_pkg::CsrMaxPort:   max_ff <= csr_wdata;
               pba_pkg::CsrBlockSize: bs_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.zero_nblk) begin
         nblk_ff <= '0;
      end else if (cmd.load_nblk) begin
         nblk_ff <= nblk_calc;
      end
      if (cmd.scan_start) begin
         grp_ff <= '0;
      end else if (cmd.scan_step) begin
         grp_ff <= grp_ff + pba_pkg::GrpW'(1);
         idx_ff <= hit_idx;
      end
      if (cmd.grant_mul) begin
         prod_ff <= prod_full[pba_pkg::PortW-1:0];
      end
      if (cmd.set_status) begin
         st_ff <= cmd.status;
      end
      if (cmd.latch_req) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else if (cmd.grant_fin) begin
         lo_ff <= lo_calc;
         hi_ff <= hi_calc;
      end
      if (cmd.load_out) begin
         out_ff.status      <= st_ff;
         out_ff.low_port    <= lo_ff;
         out_ff.high_port   <= hi_ff;
         out_ff.taken_count <= total_ff;
      end
   end

   assign rsp_data = out_ff;

   always_comb begin
      stat.kind       = req_ff.kind;
      stat.span_ok    = (bs_ff != '0) && (max_ff > min_ff);
      stat.count_big  = req_ff.port_count > bs_ff;
      stat.port_bad   = (bs_ff == '0) || (req_ff.range_low_port < min_ff);
      stat.nblk_zero  = nblk_ff == '0;
      stat.total_zero = total_ff == '0;
      stat.div_done   = div_done;
      stat.scan_hit   = |scan_cand;
      stat.scan_last  = grp_ff == pba_pkg::GrpW'(pba_pkg::NumGroups - 1);
      stat.free_bad   = (div_r != '0) || (div_q >= pba_pkg::PortW'(nblk_ff));
      stat.free_taken = taken_ff[div_q[pba_pkg::BlkIdxW-1:0]];
   end

   `PBA_ASSERT_NOW(a_total_matches_map, clock, reset, 1'b1, total_ff == pba_pkg::CntW'($countones(taken_ff)), "taken count disagrees with block map")
   `PBA_ASSERT_NOW(a_grant_free_block, clock, reset, cmd.grant_fin, !taken_ff[idx_ff], "granting a block that is already taken")
   `PBA_ASSERT_NOW(a_free_taken_block, clock, reset, cmd.free_clear, taken_ff[div_q[pba_pkg::BlkIdxW-1:0]], "freeing a block that is not taken")

endmodule

### hw/rtl/pba_ctrl.sv
`include "port_block_allocator_core_defines.svh"

module pba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pba_pkg::stat_type stat,
   output pba_pkg::cmd_type  cmd
);

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StChk    = 4'd1;
   localparam logic [3:0] StDspan  = 4'd2;
   localparam logic [3:0] StDecide = 4'd3;
   localparam logic [3:0] StScan   = 4'd4;
   localparam logic [3:0] StGmul   = 4'd5;
   localparam logic [3:0] StGfin   = 4'd6;
   localparam logic [3:0] StDport  = 4'd7;
   localparam logic [3:0] StFchk   = 4'd8;
   localparam logic [3:0] StFinish = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = StChk;
            end
         end
         StChk: begin
            if (stat.span_ok) begin
               cmd.div_span = 1'b1;
               state_in     = StDspan;
            end else begin
               cmd.zero_nblk = 1'b1;
               state_in      = StDecide;
            end
         end
         StDspan: begin
            if (stat.div_done) begin
               cmd.load_nblk = 1'b1;
               state_in      = StDecide;
            end
         end
         StDecide: begin
            if (stat.kind == pba_pkg::KindAlloc) begin
               if (stat.count_big) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = pba_pkg::StCountBig;
                  state_in       = StFinish;
               end else if (stat.nblk_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = pba_pkg::StNoneFree;
                  state_in       = StFinish;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = StScan;
               end
            end else begin
               if (stat.total_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = pba_pkg::StNotTaken;
                  state_in       = StFinish;
               end else if (stat.port_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = pba_pkg::StBadPort;
                  state_in       = StFinish;
               end else begin
                  cmd.div_port = 1'b1;
                  state_in     = StDport;
               end
            end
         end
         StScan: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               state_in = StGmul;
            end else if (stat.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = pba_pkg::StNoneFree;
               state_in       = StFinish;
            end
         end
         StGmul: begin
            cmd.grant_mul = 1'b1;
            state_in      = StGfin;
         end
         StGfin: begin
            cmd.grant_fin  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = pba_pkg::StOk;
            state_in       = StFinish;
         end
         StDport: begin
            if (stat.div_done) begin
               state_in = StFchk;
            end
         end
         StFchk: begin
            cmd.set_status = 1'b1;
            if (stat.free_bad) begin
               cmd.status = pba_pkg::StBadPort;
            end else if (!stat.free_taken) begin
               cmd.status = pba_pkg::StNotTaken;
            end else begin
               cmd.free_clear = 1'b1;
               cmd.status     = pba_pkg::StOk;
            end
            state_in = StFinish;
         end
         StFinish: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != StIdle;
   assign rsp_valid = rsp_valid_ff;

   `PBA_ASSERT_NEXT(a_accept_starts_item, clock, reset, req_valid && !req_stall, state_ff == StChk, "accepted request did not start processing")
   `PBA_ASSERT_NOW(a_no_result_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || !rsp_stall, "result register overwritten while stalled")

endmodule

### hw/rtl/port_block_allocator_core.sv
// Channel   Direction  Handshake         Payload
// req_      in         req_valid/stall   kind, port_count, range_low_port
// rsp_      out        rsp_valid/stall   status, low_port, high_port, taken_count
// csr_      in         csr_we            csr_index, csr_wdata (no wait, no read-back)
//
// One request at a time. Each division runs on the bit-serial divider: span /
// block_size on a request whose span is valid, offset / block_size on a free
// that passes its checks; an allocate then scans the map one group at a time.
// Reset is synchronous and frees every block; no clearing pass is needed.
// A finished result sits in the output register; the next request is taken
// while it waits, and only the following result waits on rsp_stall.
module port_block_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pba_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pba_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [pba_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pba_pkg::PortW-1:0]   csr_wdata
);

   pba_pkg::cmd_type  cmd;
   pba_pkg::stat_type stat;

   pba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule
